### rtl/named_counting_semaphore_table_assert.svh
// assertion macros for the named counting semaphore table
`ifndef NAMED_COUNTING_SEMAPHORE_TABLE_ASSERT_SVH
`define NAMED_COUNTING_SEMAPHORE_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define NCST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ncst assertion failed");
`define NCST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ncst assertion failed");
`else
`define NCST_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define NCST_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/ncst_pkg.sv
// shared types, codes and helpers of the named counting semaphore table
package ncst_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int NAME_BYTES_DEF = 8;

  localparam int OP_W   = 3;
  localparam int NAME_W = 64;
  localparam int CNT_W  = 16;
  localparam int IDX_W  = 4;
  localparam int STAT_W = 2;

  localparam logic [OP_W-1:0] OP_OPEN   = 3'd0;
  localparam logic [OP_W-1:0] OP_WAIT   = 3'd1;
  localparam logic [OP_W-1:0] OP_POST   = 3'd2;
  localparam logic [OP_W-1:0] OP_GET    = 3'd3;
  localparam logic [OP_W-1:0] OP_UNLINK = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;

  // keep bytes up to the first zero byte, within the name length
  function automatic logic [NAME_W-1:0] ncst_norm_name(input logic [NAME_W-1:0] raw,
                                                       input int nb);
    logic [NAME_W-1:0] res;
    logic              stop;
    res  = '0;
    stop = 1'b0;
    for (int i = 0; i < NAME_W / 8; i++) begin
      if (i >= nb || raw[8*i +: 8] == 8'h00) begin
        stop = 1'b1;
      end
      if (!stop) begin
        res[8*i +: 8] = raw[8*i +: 8];
      end
    end
    return res;
  endfunction

endpackage

### rtl/named_counting_semaphore_table.sv
// named counting semaphore table: top level with scan sequencer and count unit
//
// Usage: drive an item on the in_ ports with start high while busy is low;
// that edge is the transfer. busy stays high while the item is worked on.
// One result per item appears on the out_ ports for exactly one cycle,
// marked by out_valid; the receiver cannot stall and must take it then.
// Wait, post and get value read the count (S_CNT_RD) and then work out
// the result (S_CALC); an out-of-range index or an unknown operation is
// answered straight from idle. Open and unlink walk the name memory one
// entry per cycle through its single read port (S_SCAN, S_DRAIN,
// S_DECIDE), and open goes on to S_CNT_RD and S_CALC for an existing name.
// Counts share one saturating add unit and a 1R1W count memory.
// The next item can be taken at the edge that ends the result cycle.
// Reset (rst_n low, synchronous) clears the sequencer and the per-entry
// valid bits, so every entry reads as unused with count zero; no clearing
// pass is needed and the block is ready right after reset.
module named_counting_semaphore_table #(
  parameter int ENTRIES    = ncst_pkg::ENTRIES_DEF,
  parameter int NAME_BYTES = ncst_pkg::NAME_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [ncst_pkg::OP_W-1:0]           in_operation,
  input  logic [ncst_pkg::NAME_W-1:0]         in_sem_name,
  input  logic signed [ncst_pkg::CNT_W-1:0]   in_initial_value,
  input  logic [ncst_pkg::IDX_W-1:0]          in_sem_index,
  output logic                                out_valid,
  output logic [ncst_pkg::STAT_W-1:0]         out_status,
  output logic [ncst_pkg::IDX_W-1:0]          out_handle,
  output logic signed [ncst_pkg::CNT_W-1:0]   out_count_value,
  output logic                                out_must_block,
  output logic                                out_wake_one
);
  import ncst_pkg::*;

`include "named_counting_semaphore_table_assert.svh"

  localparam int            AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int            NW    = 8 * NAME_BYTES;
  localparam logic [AW-1:0] LAST  = AW'(ENTRIES - 1);
  localparam logic [31:0]   ENT_U = 32'(ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_CNT_RD,
    S_CALC
  } state_t;

  state_t                   state_r, state_nxt;
  logic [OP_W-1:0]          op_r, op_nxt;
  logic [NW-1:0]            nm_r, nm_nxt;
  logic signed [CNT_W-1:0]  init_r, init_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [AW-1:0]            scan_addr_r, scan_addr_nxt;
  logic [AW-1:0]            cmp_addr_r, cmp_addr_nxt;
  logic                     cmp_v_r, cmp_v_nxt;
  logic                     match_f_r, match_f_nxt;
  logic [AW-1:0]            match_idx_r, match_idx_nxt;
  logic                     free_f_r, free_f_nxt;
  logic [AW-1:0]            free_idx_r, free_idx_nxt;
  logic [AW-1:0]            cnt_addr_r, cnt_addr_nxt;
  logic [ENTRIES-1:0]       name_vld_r, name_vld_nxt;
  logic [ENTRIES-1:0]       cnt_vld_r, cnt_vld_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]        out_status_r, out_status_nxt;
  logic [IDX_W-1:0]         out_handle_r, out_handle_nxt;
  logic signed [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic                     out_blk_r, out_blk_nxt;
  logic                     out_wake_r, out_wake_nxt;

  logic [NW-1:0]            name_mem [ENTRIES];
  logic signed [CNT_W-1:0]  cnt_mem [ENTRIES];
  logic [NW-1:0]            name_rd_r;
  logic signed [CNT_W-1:0]  cnt_rd_r;

  logic                     name_we;
  logic                     cnt_we;
  logic [AW-1:0]            cnt_waddr;
  logic signed [CNT_W-1:0]  cnt_wdata;

  logic [NW-1:0]            eff_name;
  logic signed [CNT_W-1:0]  eff_cnt;
  logic [1:0]               delta;
  logic [CNT_W:0]           sum_w;
  logic signed [CNT_W-1:0]  res_cnt;
  logic                     idx_ok;

  // memories
  always_ff @(posedge clk) begin
    if (name_we) begin
      name_mem[free_idx_r] <= nm_r;
    end
    name_rd_r <= name_mem[scan_addr_r];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rd_r <= cnt_mem[cnt_addr_r];
  end

  assign eff_name = name_vld_r[cmp_addr_r] ? name_rd_r : '0;
  assign eff_cnt  = cnt_vld_r[cnt_addr_r] ? cnt_rd_r : '0;

  // shared saturating add unit
  assign delta   = (op_r == OP_WAIT) ? 2'b11 : ((op_r == OP_POST) ? 2'b01 : 2'b00);
  assign sum_w   = {eff_cnt[CNT_W-1], eff_cnt} + {{(CNT_W-1){delta[1]}}, delta};
  assign res_cnt = (sum_w[CNT_W] != sum_w[CNT_W-1]) ? eff_cnt : sum_w[CNT_W-1:0];

  assign idx_ok = ({{(32-IDX_W){1'b0}}, in_sem_index} < ENT_U);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    nm_nxt         = nm_r;
    init_nxt       = init_r;
    idx_nxt        = idx_r;
    scan_addr_nxt  = scan_addr_r;
    cmp_addr_nxt   = scan_addr_r;
    cmp_v_nxt      = (state_r == S_SCAN);
    match_f_nxt    = match_f_r;
    match_idx_nxt  = match_idx_r;
    free_f_nxt     = free_f_r;
    free_idx_nxt   = free_idx_r;
    cnt_addr_nxt   = cnt_addr_r;
    name_vld_nxt   = name_vld_r;
    cnt_vld_nxt    = cnt_vld_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_handle_nxt = out_handle_r;
    out_cnt_nxt    = out_cnt_r;
    out_blk_nxt    = out_blk_r;
    out_wake_nxt   = out_wake_r;
    name_we        = 1'b0;
    cnt_we         = 1'b0;
    cnt_waddr      = free_idx_r;
    cnt_wdata      = init_r;

    // lowest matching and lowest unused entry
    if (cmp_v_r && !match_f_r && eff_name == nm_r) begin
      match_f_nxt   = 1'b1;
      match_idx_nxt = cmp_addr_r;
    end
    if (cmp_v_r && !free_f_r && eff_name[7:0] == 8'h00) begin
      free_f_nxt   = 1'b1;
      free_idx_nxt = cmp_addr_r;
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt        = in_operation;
          nm_nxt        = NW'(ncst_norm_name(in_sem_name, NAME_BYTES));
          init_nxt      = in_initial_value;
          idx_nxt       = in_sem_index;
          cnt_addr_nxt  = AW'(in_sem_index);
          scan_addr_nxt = '0;
          match_f_nxt   = 1'b0;
          free_f_nxt    = 1'b0;
          if (in_operation == OP_OPEN || in_operation == OP_UNLINK) begin
            state_nxt = S_SCAN;
          end else if ((in_operation == OP_WAIT || in_operation == OP_POST ||
                        in_operation == OP_GET) && idx_ok) begin
            state_nxt = S_CNT_RD;
          end else begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_OK;
            out_handle_nxt = in_sem_index;
            out_cnt_nxt    = '0;
            out_blk_nxt    = 1'b0;
            out_wake_nxt   = 1'b0;
          end
        end
      end
      S_SCAN: begin
        scan_addr_nxt = scan_addr_r + 1'b1;
        if (scan_addr_r == LAST) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt      = S_IDLE;
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_handle_nxt = idx_r;
        out_cnt_nxt    = '0;
        out_blk_nxt    = 1'b0;
        out_wake_nxt   = 1'b0;
        if (op_r == OP_OPEN) begin
          if (match_f_r) begin
            cnt_addr_nxt  = match_idx_r;
            out_valid_nxt = 1'b0;
            state_nxt     = S_CNT_RD;
          end else if (free_f_r) begin
            name_we                  = 1'b1;
            cnt_we                   = 1'b1;
            name_vld_nxt[free_idx_r] = 1'b1;
            cnt_vld_nxt[free_idx_r]  = 1'b1;
            out_handle_nxt           = IDX_W'(free_idx_r);
            out_cnt_nxt              = init_r;
          end else begin
            out_status_nxt = ST_FULL;
            out_handle_nxt = '0;
          end
        end else begin
          if (match_f_r) begin
            name_vld_nxt[match_idx_r] = 1'b0;
            cnt_vld_nxt[match_idx_r]  = 1'b0;
          end else begin
            out_status_nxt = ST_NOTFOUND;
          end
        end
      end
      S_CNT_RD: begin
        state_nxt = S_CALC;
      end
      S_CALC: begin
        state_nxt      = S_IDLE;
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_handle_nxt = (op_r == OP_OPEN) ? IDX_W'(cnt_addr_r) : idx_r;
        out_cnt_nxt    = res_cnt;
        out_blk_nxt    = (op_r == OP_WAIT) && res_cnt[CNT_W-1];
        out_wake_nxt   = (op_r == OP_POST) && (res_cnt[CNT_W-1] || res_cnt == '0);
        if (op_r == OP_WAIT || op_r == OP_POST) begin
          cnt_we                  = 1'b1;
          cnt_waddr               = cnt_addr_r;
          cnt_wdata               = res_cnt;
          cnt_vld_nxt[cnt_addr_r] = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    op_r           <= op_nxt;
    nm_r           <= nm_nxt;
    init_r         <= init_nxt;
    idx_r          <= idx_nxt;
    scan_addr_r    <= scan_addr_nxt;
    cmp_addr_r     <= cmp_addr_nxt;
    match_idx_r    <= match_idx_nxt;
    free_idx_r     <= free_idx_nxt;
    cnt_addr_r     <= cnt_addr_nxt;
    out_status_r   <= out_status_nxt;
    out_handle_r   <= out_handle_nxt;
    out_cnt_r      <= out_cnt_nxt;
    out_blk_r      <= out_blk_nxt;
    out_wake_r     <= out_wake_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmp_v_r     <= 1'b0;
      match_f_r   <= 1'b0;
      free_f_r    <= 1'b0;
      name_vld_r  <= '0;
      cnt_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_v_r     <= cmp_v_nxt;
      match_f_r   <= match_f_nxt;
      free_f_r    <= free_f_nxt;
      name_vld_r  <= name_vld_nxt;
      cnt_vld_r   <= cnt_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_handle      = out_handle_r;
  assign out_count_value = out_cnt_r;
  assign out_must_block  = out_blk_r;
  assign out_wake_one    = out_wake_r;

  // a named entry always carries a live count
  `NCST_ASSERT_IMP(a_name_has_cnt, clk, rst_n, 1'b1, (name_vld_r & ~cnt_vld_r) == '0)
  // a result only follows an accepted or running item
  `NCST_ASSERT_IMP(a_result_cause, clk, rst_n, out_valid_r, $past(busy || start))
  `NCST_ASSERT_IMP(a_full_zero, clk, rst_n, out_valid_r && out_status_r == ST_FULL,
                   out_handle_r == '0 && out_cnt_r == '0)
  `NCST_ASSERT_IMP(a_block_neg, clk, rst_n, out_valid_r && out_blk_r,
                   out_cnt_r[CNT_W-1] && !out_wake_r)
  `NCST_ASSERT_NXT(a_scan_end, clk, rst_n, state_r == S_SCAN && scan_addr_r == LAST,
                   state_r == S_DRAIN && cmp_v_r)

endmodule
